[hw/rtl/memory_stride_histogram_macros.svh]
// Assertion macros used by the checker.
`ifndef MEMORY_STRIDE_HISTOGRAM_MACROS_SVH
`define MEMORY_STRIDE_HISTOGRAM_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define MSH_ASSERT_SAME(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("stride histogram check failed");

// Check that a condition implies another in the next cycle.
`define MSH_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("stride histogram check failed");

`endif

[hw/rtl/msh_pkg.sv]
`timescale 1ns / 1ps

package msh_pkg;

    // Table depth is a power of two; the entry index is taken modulo the depth.
    localparam int TABLE_DEPTH   = 1024;
    localparam int COUNT_BITS    = 48;

    localparam int IDX_BITS      = $clog2(TABLE_DEPTH);
    localparam int TBL_ADDR_BITS = IDX_BITS + 1;
    localparam int ENTRY_BITS    = 10;
    localparam int ADDR_BITS     = 64;
    localparam int SIZE_BITS     = 7;
    localparam int OP_BITS       = 2;
    localparam int VALUE_BITS    = 48;
    localparam int POS_BITS      = 5;
    localparam int IN_DATA_BITS  = 88;
    localparam int OUT_DATA_BITS = 48;

    localparam int NUM_BINS      = 7;
    localparam int NUM_GROUPS    = 4;
    localparam int NUM_COUNTERS  = NUM_BINS * NUM_GROUPS;
    localparam int CTR_IDX_BITS  = $clog2(NUM_COUNTERS);
    localparam int DUMP_LEN      = 30;
    localparam int HALF_DUMP     = DUMP_LEN / 2;

    // Opcodes
    localparam logic [OP_BITS-1:0] OP_READ  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_BITS-1:0] OP_DUMP  = 2'd2;

    // Counter groups
    localparam logic [1:0] GRP_LOCAL_RD  = 2'd0;
    localparam logic [1:0] GRP_GLOBAL_RD = 2'd1;
    localparam logic [1:0] GRP_LOCAL_WR  = 2'd2;
    localparam logic [1:0] GRP_GLOBAL_WR = 2'd3;

    // Bin code for a stride that is not counted
    localparam logic [2:0] BIN_NONE = 3'd7;

    localparam logic [ADDR_BITS-1:0] BIN_UP_1 = 64'd8;
    localparam logic [ADDR_BITS-1:0] BIN_UP_2 = 64'd64;
    localparam logic [ADDR_BITS-1:0] BIN_UP_3 = 64'd512;
    localparam logic [ADDR_BITS-1:0] BIN_UP_4 = 64'd4096;
    localparam logic [ADDR_BITS-1:0] BIN_UP_5 = 64'd32768;
    localparam logic [ADDR_BITS-1:0] BIN_UP_6 = 64'd262144;

    typedef logic [COUNT_BITS-1:0] count_t;

    // Stride bins of one access, handed to the counter stage
    typedef struct packed {
        logic       valid;
        logic       is_write;
        logic [2:0] local_bin;
        logic [2:0] global_bin;
    } upd_t;

    // What a dump position reports
    typedef struct packed {
        logic                    is_count;
        logic                    is_write;
        logic                    first_bin;
        logic [CTR_IDX_BITS-1:0] ctr_idx;
    } pos_info_t;

    function automatic logic [ADDR_BITS-1:0] abs_diff(
        input logic [ADDR_BITS-1:0] a,
        input logic [ADDR_BITS-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [2:0] bin_of(input logic [ADDR_BITS-1:0] stride);
        logic [2:0] code;
        if (stride == '0)
            code = 3'd0;
        else if (stride <= BIN_UP_1)
            code = 3'd1;
        else if (stride <= BIN_UP_2)
            code = 3'd2;
        else if (stride <= BIN_UP_3)
            code = 3'd3;
        else if (stride <= BIN_UP_4)
            code = 3'd4;
        else if (stride <= BIN_UP_5)
            code = 3'd5;
        else if (stride <= BIN_UP_6)
            code = 3'd6;
        else
            code = BIN_NONE;
        return code;
    endfunction

    function automatic count_t sat_add(input count_t a, input count_t b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
    endfunction

    function automatic pos_info_t pos_decode(input logic [POS_BITS-1:0] pos);
        pos_info_t       info;
        logic [POS_BITS-1:0] q;
        logic [1:0]      grp;
        logic [2:0]      bin;
        info.is_write = (pos >= POS_BITS'(HALF_DUMP));
        q = info.is_write ? (pos - POS_BITS'(HALF_DUMP)) : pos;
        info.is_count = (q == '0);
        if (q <= POS_BITS'(NUM_BINS))
        begin
            grp = info.is_write ? GRP_LOCAL_WR : GRP_LOCAL_RD;
            bin = 3'(q - POS_BITS'(1));
        end
        else
        begin
            grp = info.is_write ? GRP_GLOBAL_WR : GRP_GLOBAL_RD;
            bin = 3'(q - POS_BITS'(NUM_BINS + 1));
        end
        info.first_bin = (bin == 3'd0);
        info.ctr_idx   = CTR_IDX_BITS'(int'(grp) * NUM_BINS + int'(bin));
        return info;
    endfunction

endpackage

[hw/rtl/msh_end_table.sv]
`timescale 1ns / 1ps

// End-address table for both access kinds, with a clearing pass after reset
// and forwarding of the write made in the cycle of a read.
module msh_end_table (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  rd_en,
    input  logic [msh_pkg::TBL_ADDR_BITS-1:0]     rd_addr,
    output logic [msh_pkg::ADDR_BITS-1:0]         rd_data,
    input  logic                                  wr_en,
    input  logic [msh_pkg::TBL_ADDR_BITS-1:0]     wr_addr,
    input  logic [msh_pkg::ADDR_BITS-1:0]         wr_data,
    output logic                                  busy
);

    logic [msh_pkg::ADDR_BITS-1:0] mem [0:(2 * msh_pkg::TABLE_DEPTH)-1];

    logic                               clr_active_reg, clr_active_next;
    logic [msh_pkg::TBL_ADDR_BITS-1:0]  clr_addr_reg, clr_addr_next;
    logic                               lw_valid_reg, lw_valid_next;
    logic [msh_pkg::TBL_ADDR_BITS-1:0]  lw_addr_reg;
    logic [msh_pkg::ADDR_BITS-1:0]      lw_data_reg;
    logic [msh_pkg::TBL_ADDR_BITS-1:0]  rd_addr_reg;
    logic [msh_pkg::ADDR_BITS-1:0]      mem_q_reg;

    logic                               port_wr_en;
    logic [msh_pkg::TBL_ADDR_BITS-1:0]  port_wr_addr;
    logic [msh_pkg::ADDR_BITS-1:0]      port_wr_data;

    // Sweep the table with zeros after reset, else take the pipeline write
    always_comb
    begin
        port_wr_en      = clr_active_reg | wr_en;
        port_wr_addr    = clr_active_reg ? clr_addr_reg : wr_addr;
        port_wr_data    = clr_active_reg ? '0 : wr_data;
        clr_addr_next   = clr_addr_reg + 1'b1;
        clr_active_next = clr_active_reg & (clr_addr_reg != '1);
        lw_valid_next   = port_wr_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            lw_valid_reg   <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            lw_valid_reg   <= lw_valid_next;
        end
    end

    // Memory port: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (port_wr_en)
            mem[port_wr_addr] <= port_wr_data;
        if (rd_en)
        begin
            mem_q_reg   <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        lw_addr_reg <= port_wr_addr;
        lw_data_reg <= port_wr_data;
    end

    // Forward the write that raced the read
    assign rd_data = (lw_valid_reg && (lw_addr_reg == rd_addr_reg)) ? lw_data_reg : mem_q_reg;
    assign busy    = clr_active_reg;

endmodule

[hw/rtl/msh_stats.sv]
`timescale 1ns / 1ps

// Access and bin counters, dump sequencer and output register.
module msh_stats (
    input  logic                               clk,
    input  logic                               rst_n,
    input  msh_pkg::upd_t                      upd,
    input  logic                               dump_start,
    output logic                               busy,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [msh_pkg::VALUE_BITS-1:0]     out_value,
    output logic [msh_pkg::POS_BITS-1:0]       out_pos,
    output logic                               out_last
);

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_RUN  = 2'b10
    } seq_state_t;

    seq_state_t                       state_reg, state_next;
    logic [msh_pkg::POS_BITS-1:0]     pos_reg, pos_next;
    msh_pkg::count_t                  cum_reg, cum_next;
    msh_pkg::count_t                  rd_count_reg, rd_count_next;
    msh_pkg::count_t                  wr_count_reg, wr_count_next;
    msh_pkg::count_t                  bin_reg  [msh_pkg::NUM_COUNTERS];
    msh_pkg::count_t                  bin_next [msh_pkg::NUM_COUNTERS];
    logic                             out_valid_reg, out_valid_next;
    logic [msh_pkg::VALUE_BITS-1:0]   out_value_reg, out_value_next;
    logic [msh_pkg::POS_BITS-1:0]     out_pos_reg, out_pos_next;
    logic                             out_last_reg, out_last_next;

    msh_pkg::pos_info_t               info;
    msh_pkg::count_t                  sel_value;
    msh_pkg::count_t                  cum_base;
    logic                             load;
    logic                             final_load;
    logic [msh_pkg::CTR_IDX_BITS-1:0] local_idx;
    logic [msh_pkg::CTR_IDX_BITS-1:0] global_idx;
    logic                             local_hit_ok;
    logic                             global_hit_ok;

    // Counter slots hit by the access in this stage
    always_comb
    begin
        local_idx  = msh_pkg::CTR_IDX_BITS'(
            int'(upd.is_write ? msh_pkg::GRP_LOCAL_WR : msh_pkg::GRP_LOCAL_RD)
            * msh_pkg::NUM_BINS + int'(upd.local_bin));
        global_idx = msh_pkg::CTR_IDX_BITS'(
            int'(upd.is_write ? msh_pkg::GRP_GLOBAL_WR : msh_pkg::GRP_GLOBAL_RD)
            * msh_pkg::NUM_BINS + int'(upd.global_bin));
        local_hit_ok  = upd.valid && (upd.local_bin != msh_pkg::BIN_NONE);
        global_hit_ok = upd.valid && (upd.global_bin != msh_pkg::BIN_NONE);
    end

    // Pick the value for the current dump position
    always_comb
    begin
        info     = msh_pkg::pos_decode(pos_reg);
        cum_base = info.first_bin ? '0 : cum_reg;
        if (info.is_count)
            sel_value = info.is_write ? wr_count_reg : rd_count_reg;
        else
            sel_value = msh_pkg::sat_add(cum_base, bin_reg[info.ctr_idx]);
    end

    always_comb
    begin
        load       = (state_reg == SEQ_RUN) && (!out_valid_reg || out_ready);
        final_load = load && (pos_reg == msh_pkg::POS_BITS'(msh_pkg::DUMP_LEN - 1));

        state_next     = state_reg;
        pos_next       = pos_reg;
        cum_next       = cum_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_value_next = out_value_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            SEQ_IDLE:
            begin
                if (dump_start)
                begin
                    state_next = SEQ_RUN;
                    pos_next   = '0;
                end
            end
            SEQ_RUN:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = msh_pkg::VALUE_BITS'(sel_value);
                    out_pos_next   = pos_reg;
                    out_last_next  = final_load;
                    cum_next       = sel_value;
                    pos_next       = pos_reg + 1'b1;
                    if (final_load)
                        state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase

        // Count accesses; clear everything when the last dump value is loaded for output
        rd_count_next = rd_count_reg;
        wr_count_next = wr_count_reg;
        if (upd.valid && !upd.is_write)
            rd_count_next = msh_pkg::sat_add(rd_count_reg, msh_pkg::count_t'(1));
        if (upd.valid && upd.is_write)
            wr_count_next = msh_pkg::sat_add(wr_count_reg, msh_pkg::count_t'(1));
        for (int k = 0; k < msh_pkg::NUM_COUNTERS; k++)
        begin
            if ((local_hit_ok && (local_idx == msh_pkg::CTR_IDX_BITS'(k))) ||
                (global_hit_ok && (global_idx == msh_pkg::CTR_IDX_BITS'(k))))
                bin_next[k] = msh_pkg::sat_add(bin_reg[k], msh_pkg::count_t'(1));
            else
                bin_next[k] = bin_reg[k];
        end
        if (final_load)
        begin
            rd_count_next = '0;
            wr_count_next = '0;
            for (int k = 0; k < msh_pkg::NUM_COUNTERS; k++)
                bin_next[k] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            out_valid_reg <= 1'b0;
            rd_count_reg  <= '0;
            wr_count_reg  <= '0;
            for (int k = 0; k < msh_pkg::NUM_COUNTERS; k++)
                bin_reg[k] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rd_count_reg  <= rd_count_next;
            wr_count_reg  <= wr_count_next;
            for (int k = 0; k < msh_pkg::NUM_COUNTERS; k++)
                bin_reg[k] <= bin_next[k];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        cum_reg       <= cum_next;
        out_value_reg <= out_value_next;
        out_pos_reg   <= out_pos_next;
        out_last_reg  <= out_last_next;
    end

    assign busy      = (state_reg == SEQ_RUN);
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_pos   = out_pos_reg;
    assign out_last  = out_last_reg;

endmodule

[hw/rtl/memory_stride_histogram.sv]
`timescale 1ns / 1ps

// Channel   Group    Contents
// input     s_axis   tuser: opcode; tdata: entry_index, address, access_bytes
// output    m_axis   tdata: value; tuser: position; tlast: last
//
// Reads and writes are taken one per cycle while s_axis_tready is high; each
// goes through table read, stride compare and bin update in three stages, with
// the end-address table write of one access forwarded to a read of the same entry
// in the next cycle. A dump holds off input from acceptance until its 30th value
// sits in the output register; values leave one per cycle while m_axis_tready
// is high. After reset all 2 * TABLE_DEPTH (2048) end-address table entries
// are zeroed one entry a cycle, with s_axis_tready low.
module memory_stride_histogram (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [9:0] entry_index, [73:10] address, [80:74] access_bytes, [87:81] zero
    input  logic [msh_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
    // [1:0] opcode
    input  logic [msh_pkg::OP_BITS-1:0]          s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [47:0] value
    output logic [msh_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
    // [4:0] position
    output logic [msh_pkg::POS_BITS-1:0]         m_axis_tuser,
    output logic                                 m_axis_tlast
);

    logic [msh_pkg::ENTRY_BITS-1:0]     in_entry;
    logic [msh_pkg::ADDR_BITS-1:0]      in_addr;
    logic [msh_pkg::SIZE_BITS-1:0]      in_bytes;
    logic                               in_fire;
    logic                               in_access;
    logic [msh_pkg::TBL_ADDR_BITS-1:0]  in_tbl_addr;
    logic [msh_pkg::ADDR_BITS-1:0]      in_end;

    logic                               s1_valid_reg, s1_valid_next;
    logic                               s1_dump_reg, s1_dump_next;
    logic                               s1_write_reg;
    logic [msh_pkg::TBL_ADDR_BITS-1:0]  s1_tbl_addr_reg;
    logic [msh_pkg::ADDR_BITS-1:0]      s1_addr_reg;
    logic [msh_pkg::ADDR_BITS-1:0]      s1_end_reg;
    logic [msh_pkg::ADDR_BITS-1:0]      last_rd_end_reg, last_rd_end_next;
    logic [msh_pkg::ADDR_BITS-1:0]      last_wr_end_reg, last_wr_end_next;
    msh_pkg::upd_t                      s2_upd_reg, s2_upd_next;

    logic [msh_pkg::ADDR_BITS-1:0]      entry_end;
    logic [msh_pkg::ADDR_BITS-1:0]      global_end;
    logic                               tbl_busy;
    logic                               stats_busy;

    // Unpack the input transfer
    assign in_entry  = s_axis_tdata[msh_pkg::ENTRY_BITS-1:0];
    assign in_addr   = s_axis_tdata[msh_pkg::ENTRY_BITS +: msh_pkg::ADDR_BITS];
    assign in_bytes  = s_axis_tdata[msh_pkg::ENTRY_BITS + msh_pkg::ADDR_BITS +:
                                    msh_pkg::SIZE_BITS];

    assign s_axis_tready = !tbl_busy && !stats_busy && !s1_dump_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_access     = (s_axis_tuser == msh_pkg::OP_READ) ||
                           (s_axis_tuser == msh_pkg::OP_WRITE);
    assign in_tbl_addr   = {s_axis_tuser[0], msh_pkg::IDX_BITS'(in_entry)};
    assign in_end        = in_addr + msh_pkg::ADDR_BITS'(in_bytes) - 1'b1;

    // Stage 1: compare against the stored ends, write the new end back
    always_comb
    begin
        global_end       = s1_write_reg ? last_wr_end_reg : last_rd_end_reg;
        last_rd_end_next = last_rd_end_reg;
        last_wr_end_next = last_wr_end_reg;
        if (s1_valid_reg && !s1_write_reg)
            last_rd_end_next = s1_end_reg;
        if (s1_valid_reg && s1_write_reg)
            last_wr_end_next = s1_end_reg;

        s2_upd_next.valid      = s1_valid_reg;
        s2_upd_next.is_write   = s1_write_reg;
        s2_upd_next.local_bin  = msh_pkg::bin_of(msh_pkg::abs_diff(s1_addr_reg, entry_end));
        s2_upd_next.global_bin = msh_pkg::bin_of(msh_pkg::abs_diff(s1_addr_reg, global_end));

        s1_valid_next = in_fire && in_access;
        s1_dump_next  = in_fire && (s_axis_tuser == msh_pkg::OP_DUMP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s1_dump_reg     <= 1'b0;
            s2_upd_reg      <= '0;
            last_rd_end_reg <= '0;
            last_wr_end_reg <= '0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            s1_dump_reg     <= s1_dump_next;
            s2_upd_reg      <= s2_upd_next;
            last_rd_end_reg <= last_rd_end_next;
            last_wr_end_reg <= last_wr_end_next;
        end
    end

    // Hold the access payload for stage 1
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_write_reg    <= s_axis_tuser[0];
            s1_tbl_addr_reg <= in_tbl_addr;
            s1_addr_reg     <= in_addr;
            s1_end_reg      <= in_end;
        end
    end

    msh_end_table u_end_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire && in_access),
        .rd_addr (in_tbl_addr),
        .rd_data (entry_end),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_tbl_addr_reg),
        .wr_data (s1_end_reg),
        .busy    (tbl_busy)
    );

    // Stage 2: count, and stream a dump out
    msh_stats u_stats (
        .clk        (clk),
        .rst_n      (rst_n),
        .upd        (s2_upd_reg),
        .dump_start (s1_dump_reg),
        .busy       (stats_busy),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_value  (m_axis_tdata),
        .out_pos    (m_axis_tuser),
        .out_last   (m_axis_tlast)
    );

endmodule

[hw/rtl/msh_checker.sv]
`timescale 1ns / 1ps
`include "memory_stride_histogram_macros.svh"

module msh_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tready,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [msh_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
    input  logic [msh_pkg::POS_BITS-1:0]         m_axis_tuser,
    input  logic                                 m_axis_tlast
);

    // The final value of a dump carries the last position
    `MSH_ASSERT_SAME(a_last_pos, clk, rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser == msh_pkg::POS_BITS'(msh_pkg::DUMP_LEN - 1))

    // A dump keeps streaming without gaps until its last value
    `MSH_ASSERT_NEXT(a_dump_gapless, clk, rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)

    // No input is taken while a dump is still being read out
    `MSH_ASSERT_SAME(a_input_held, clk, rst_n, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

    // A stalled output transfer holds its payload
    `MSH_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind memory_stride_histogram msh_checker u_msh_checker (.*);

[tb/memory_stride_histogram_tb.sv]
`timescale 1ns / 1ps

module memory_stride_histogram_tb;

    localparam int LIMIT        = 400000;
    localparam int ACCESS_ITEMS = 410;
    localparam int NO_BIN       = 7;
    localparam int BINS         = msh_pkg::NUM_BINS;
    localparam int DEPTH        = msh_pkg::TABLE_DEPTH;
    localparam logic [msh_pkg::OP_BITS-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [9:0]  idx;
        logic [63:0] addr;
        logic [6:0]  size;
        bit          drain;
    } access_t;

    typedef struct {
        logic [47:0] value;
        logic [4:0]  pos;
        logic        last;
    } dump_word_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [msh_pkg::IN_DATA_BITS-1:0]   s_axis_tdata = '0;
    logic [msh_pkg::OP_BITS-1:0]        s_axis_tuser = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic [msh_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata;
    logic [msh_pkg::POS_BITS-1:0]       m_axis_tuser;
    logic                               m_axis_tlast;

    memory_stride_histogram i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    // Stride profile state mirrored by the testbench
    logic [63:0] rd_end_tbl [DEPTH];
    logic [63:0] wr_end_tbl [DEPTH];
    logic [63:0] last_rd_end;
    logic [63:0] last_wr_end;
    logic [47:0] rd_count;
    logic [47:0] wr_count;
    logic [47:0] hist [4*BINS];

    access_t    access_queue [$];
    dump_word_t dump_words_due [$];
    access_t    on_bus;
    dump_word_t seen_word;

    int burst_left = 1;
    int gap_left = 0;
    logic next_valid;
    int ready_phase = 0;
    int stall_mode = 0;
    int cycle_cnt = 0;
    int mismatches = 0;
    int words_checked = 0;
    int n_reads = 0;
    int n_writes = 0;
    int n_dumps = 0;
    int n_ignored = 0;
    int n_queued = 0;
    int n_sent = 0;

    logic [63:0] stream_addr [8];
    logic [63:0] stream_step [8];
    logic [9:0]  stream_idx [8];

    function automatic logic [63:0] bin_ceiling(input int b);
        case (b)
            0:       return 64'd0;
            1:       return 64'd8;
            2:       return 64'd64;
            3:       return 64'd512;
            4:       return 64'd4096;
            5:       return 64'd32768;
            default: return 64'd262144;
        endcase
    endfunction

    function automatic int stride_bin(input logic [63:0] stride);
        for (int b = 0; b < BINS; b++)
            if (stride <= bin_ceiling(b))
                return b;
        return NO_BIN;
    endfunction

    function automatic logic [63:0] distance(input logic [63:0] a, input logic [63:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [47:0] bump(input logic [47:0] c);
        return (&c) ? c : c + 48'd1;
    endfunction

    function automatic logic [47:0] add_sat(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? '1 : s[47:0];
    endfunction

    function automatic dump_word_t dump_word(input logic [47:0] v, input int pos);
        dump_word_t w;
        w.value = v;
        w.pos   = 5'(pos);
        w.last  = (pos == msh_pkg::DUMP_LEN - 1);
        return w;
    endfunction

    task automatic tally(input int grp, input logic [63:0] stride);
        int b;
        b = stride_bin(stride);
        if (b != NO_BIN)
            hist[grp*BINS + b] = bump(hist[grp*BINS + b]);
    endtask

    // Update the profile for one accepted transfer; a dump queues its 30 values
    task automatic profile_access(input access_t a);
        int slot;
        int pos;
        logic [63:0] end_addr;
        logic [47:0] cum;
        slot = int'(a.idx) % DEPTH;
        end_addr = a.addr + 64'(a.size) - 64'd1;
        case (a.op)
            msh_pkg::OP_READ:
            begin
                rd_count = bump(rd_count);
                tally(int'(msh_pkg::GRP_LOCAL_RD), distance(a.addr, rd_end_tbl[slot]));
                rd_end_tbl[slot] = end_addr;
                tally(int'(msh_pkg::GRP_GLOBAL_RD), distance(a.addr, last_rd_end));
                last_rd_end = end_addr;
                n_reads++;
            end
            msh_pkg::OP_WRITE:
            begin
                wr_count = bump(wr_count);
                tally(int'(msh_pkg::GRP_LOCAL_WR), distance(a.addr, wr_end_tbl[slot]));
                wr_end_tbl[slot] = end_addr;
                tally(int'(msh_pkg::GRP_GLOBAL_WR), distance(a.addr, last_wr_end));
                last_wr_end = end_addr;
                n_writes++;
            end
            msh_pkg::OP_DUMP:
            begin
                pos = 0;
                for (int half = 0; half < 2; half++)
                begin
                    dump_words_due.push_back(dump_word(half ? wr_count : rd_count, pos));
                    pos++;
                    for (int grp = 2*half; grp < 2*half + 2; grp++)
                    begin
                        cum = '0;
                        for (int b = 0; b < BINS; b++)
                        begin
                            cum = add_sat(cum, hist[grp*BINS + b]);
                            dump_words_due.push_back(dump_word(cum, pos));
                            pos++;
                        end
                    end
                end
                rd_count = '0;
                wr_count = '0;
                for (int k = 0; k < 4*BINS; k++)
                    hist[k] = '0;
                n_dumps++;
            end
            default:
                n_ignored++;
        endcase
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic queue_access(input logic [1:0] op, input logic [9:0] idx,
                                input logic [63:0] addr, input logic [6:0] size,
                                input bit drain);
        access_t a;
        a.op    = op;
        a.idx   = idx;
        a.addr  = addr;
        a.size  = size;
        a.drain = drain;
        access_queue.push_back(a);
        n_queued++;
    endtask

    // Drive accesses in bursts; predict each transfer as it is accepted
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            next_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                profile_access(on_bus);
                n_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (access_queue.size() > 0 &&
                         !(access_queue[0].drain &&
                           (dump_words_due.size() > 0 || m_axis_tvalid)))
                begin
                    on_bus = access_queue.pop_front();
                    next_valid = 1'b1;
                    s_axis_tdata <= {7'd0, on_bus.size, on_bus.addr, on_bus.idx};
                    s_axis_tuser <= on_bus.op;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                                 : $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // Stall the output side on a pattern that changes every so often
    always @(posedge clk)
    begin
        ready_phase++;
        if (ready_phase % 97 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 9) < 7);
            2:       m_axis_tready <= (ready_phase % 8 != 3) && (ready_phase % 8 != 6);
            default: m_axis_tready <= (ready_phase % 16 < 5);
        endcase
    end

    // Compare every output transfer with the oldest predicted dump value
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (dump_words_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected value %0h at position %0d",
                                          m_axis_tdata, m_axis_tuser));
            end
            else
            begin
                seen_word = dump_words_due.pop_front();
                words_checked++;
                if (m_axis_tdata !== seen_word.value || m_axis_tuser !== seen_word.pos ||
                    m_axis_tlast !== seen_word.last)
                    report_mismatch($sformatf(
                        "value %0h pos %0d last %b, expected value %0h pos %0d last %b",
                        m_axis_tdata, m_axis_tuser, m_axis_tlast,
                        seen_word.value, seen_word.pos, seen_word.last));
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        int made;
        int r;
        int s;
        int k;
        bit hold;
        logic [63:0] a;
        logic [63:0] chain_end;
        logic [1:0]  op;

        for (int i = 0; i < DEPTH; i++)
        begin
            rd_end_tbl[i] = '0;
            wr_end_tbl[i] = '0;
        end
        for (int i = 0; i < 4*BINS; i++)
            hist[i] = '0;
        last_rd_end = '0;
        last_wr_end = '0;
        rd_count = '0;
        wr_count = '0;

        // Directed: zero stride, then a chain that walks every bin edge
        queue_access(msh_pkg::OP_READ, 10'd0, 64'd0, 7'd1, 1'b0);
        chain_end = 64'd1000;
        queue_access(msh_pkg::OP_READ, 10'd10, chain_end, 7'd1, 1'b0);
        for (int b = 0; b < BINS; b++)
        begin
            chain_end = chain_end + bin_ceiling(b);
            queue_access(msh_pkg::OP_READ, 10'd10, chain_end, 7'd1, 1'b0);
            chain_end = chain_end + bin_ceiling(b) + 64'd1;
            queue_access(msh_pkg::OP_READ, 10'd10, chain_end, 7'd1, 1'b0);
        end
        // End address wraps past the top; zero and oversize byte counts
        queue_access(msh_pkg::OP_WRITE, 10'h3FF, '1, 7'h7F, 1'b0);
        queue_access(msh_pkg::OP_WRITE, 10'h3FF, 64'd100, 7'd0, 1'b0);
        queue_access(msh_pkg::OP_WRITE, 10'd0, 64'h8000_0000_0000_0000, 7'd64, 1'b0);
        queue_access(OP_UNUSED, 10'h3FF, '1, 7'h7F, 1'b0);
        queue_access(msh_pkg::OP_READ, 10'h3FF, 64'hAAAA_AAAA_5555_5555, 7'd64, 1'b0);
        queue_access(msh_pkg::OP_DUMP, 10'd0, 64'd0, 7'd1, 1'b0);

        // Random: strided streams per table slot, with noise mixed in
        for (s = 0; s < 8; s++)
        begin
            stream_idx[s]  = (s == 0) ? 10'd0 : (s == 7) ? 10'h3FF
                                               : 10'($urandom_range(0, 1023));
            stream_addr[s] = {$urandom, $urandom};
            stream_step[s] = 64'(1) << (2*s);
        end
        made = 0;
        while (made < ACCESS_ITEMS)
        begin
            r = $urandom_range(0, 99);
            hold = (made == 0) || (made == ACCESS_ITEMS / 2);
            if (r < 3)
            begin
                queue_access(msh_pkg::OP_DUMP, 10'($urandom_range(0, 1023)),
                             {$urandom, $urandom}, 7'($urandom_range(0, 127)), hold);
                made++;
            end
            else if (r < 5)
            begin
                queue_access(OP_UNUSED, 10'($urandom_range(0, 1023)),
                             {$urandom, $urandom}, 7'($urandom_range(0, 127)), hold);
            end
            else if (r < 13)
            begin
                op = $urandom_range(0, 1) ? msh_pkg::OP_WRITE : msh_pkg::OP_READ;
                queue_access(op, 10'($urandom_range(0, 1023)), {$urandom, $urandom},
                             7'($urandom_range(0, 127)), hold);
                made++;
            end
            else
            begin
                s = $urandom_range(0, 7);
                if ($urandom_range(0, 7) == 0)
                begin
                    k = $urandom_range(0, 7);
                    if (k == 7)
                        stream_step[s] = {$urandom, $urandom};
                    else if (k == 0)
                        stream_step[s] = '0;
                    else
                        stream_step[s] = 64'($urandom_range(32'(bin_ceiling(k)),
                                                            32'(bin_ceiling(k-1)) + 1));
                end
                a = ($urandom_range(0, 3) == 0) ? stream_addr[s] - stream_step[s]
                                                : stream_addr[s] + stream_step[s];
                op = ($urandom_range(0, 9) < 6) ? msh_pkg::OP_READ : msh_pkg::OP_WRITE;
                queue_access(op, stream_idx[s], a, 7'(1 << $urandom_range(0, 6)), hold);
                stream_addr[s] = a;
                made++;
            end
        end
        // Flush the final interval
        queue_access(msh_pkg::OP_DUMP, 10'd0, 64'd0, 7'd1, 1'b0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every access accepted, all dump values seen, then let the pipe settle
        while (n_sent < n_queued)
            @(posedge clk);
        while (dump_words_due.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("run covered %0d reads, %0d writes, %0d dumps, %0d unused opcodes",
                 n_reads, n_writes, n_dumps, n_ignored);
        $display("%0d dump values compared, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
